FILE: design/oip_pkg.sv
package oip_pkg;

   localparam int COORD_BITS_DEFAULT = 32;
   localparam int FIELD_BITS         = 32;
   localparam int CHUNK_BITS         = 32;

   localparam logic ACT_ORIENT   = 1'b0;
   localparam logic ACT_INCIRCLE = 1'b1;

   localparam logic signed [1:0] ORIENT_CCW       = 2'sb01;
   localparam logic signed [1:0] ORIENT_COLLINEAR = 2'sb00;
   localparam logic signed [1:0] ORIENT_CW        = 2'sb11;

   typedef struct packed {
      logic                         action;
      logic signed [FIELD_BITS-1:0] ax;
      logic signed [FIELD_BITS-1:0] ay;
      logic signed [FIELD_BITS-1:0] bx;
      logic signed [FIELD_BITS-1:0] by_coord;
      logic signed [FIELD_BITS-1:0] cx;
      logic signed [FIELD_BITS-1:0] cy;
      logic signed [FIELD_BITS-1:0] dx;
      logic signed [FIELD_BITS-1:0] dy;
   } req_type;

   typedef struct packed {
      logic signed [1:0] orient_sign;
      logic              inside_circle;
   } rsp_type;

   // chunks of a signed operand: unsigned low chunks, signed top chunk of up to CHUNK_BITS+1
   function automatic int oip_chunks(input int width);
      return (width - 2) / CHUNK_BITS + 1;
   endfunction

   function automatic int oip_clog2(input int value);
      int res;
      res = 0;
      for (int k = 0; k < 31; k++) begin
         if ((1 << k) < value) begin
            res = k + 1;
         end
      end
      return res;
   endfunction

endpackage

FILE: design/oip_delay.sv
module oip_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int k = 1; k < DEPTH; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

FILE: design/oip_mul.sv
module oip_mul
   import oip_pkg::*;
#(
   parameter int A_W    = COORD_BITS_DEFAULT + 1,
   parameter int B_W    = COORD_BITS_DEFAULT + 1,
   parameter int LEVELS = 0
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [A_W-1:0]    a,
   input  logic signed [B_W-1:0]    b,
   output logic signed [A_W+B_W-1:0] p
);

   localparam int P_W    = A_W + B_W;
   localparam int CH     = CHUNK_BITS;
   localparam int NA     = oip_chunks(A_W);
   localparam int NB     = oip_chunks(B_W);
   localparam int NPP    = NA * NB;
   localparam int LEAVES = 1 << LEVELS;
   localparam int NODES  = 2 * LEAVES - 1;
   localparam int TA     = A_W - (NA - 1) * CH;
   localparam int TB     = B_W - (NB - 1) * CH;

   logic signed [CH:0]      ca [NA];
   logic signed [CH:0]      cb [NB];
   logic signed [2*CH+1:0]  pp [NPP];
   logic signed [P_W-1:0]   node_in [NODES];
   logic signed [P_W-1:0]   node_ff [NODES];

   for (genvar gi = 0; gi < NA; gi++) begin : g_ca
      if (gi < NA - 1) begin : g_low
         assign ca[gi] = {1'b0, a[gi*CH +: CH]};
      end else begin : g_top
         assign ca[gi] = (CH+1)'($signed(a[A_W-1 -: TA]));
      end
   end

   for (genvar gj = 0; gj < NB; gj++) begin : g_cb
      if (gj < NB - 1) begin : g_low
         assign cb[gj] = {1'b0, b[gj*CH +: CH]};
      end else begin : g_top
         assign cb[gj] = (CH+1)'($signed(b[B_W-1 -: TB]));
      end
   end

   for (genvar gi = 0; gi < NA; gi++) begin : g_row
      for (genvar gj = 0; gj < NB; gj++) begin : g_col
         localparam int M  = gi * NB + gj;
         localparam int SH = (gi + gj) * CH;
         assign pp[M] = ca[gi] * cb[gj];
         assign node_in[LEAVES-1+M] = P_W'(pp[M]) <<< SH;
      end
   end

   for (genvar gm = NPP; gm < LEAVES; gm++) begin : g_pad
      assign node_in[LEAVES-1+gm] = '0;
   end

   for (genvar gk = 0; gk < LEAVES - 1; gk++) begin : g_tree
      assign node_in[gk] = node_ff[2*gk+1] + node_ff[2*gk+2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NODES; k++) begin
            node_ff[k] <= node_in[k];
         end
      end
   end

   assign p = node_ff[0];

endmodule

FILE: design/orient_incircle_predicate_unit.sv
// Channel  Dir  Handshake             Beat
// req      in   req_valid/req_stall   req_type: action, ax ay bx by_coord cx cy dx dy
// rsp      out  rsp_valid/rsp_stall   rsp_type: orient_sign, inside_circle
//
// One req beat per cycle while req_stall is low; partial-product multipliers
// of 33x33, 33x67, 33x101 and 67x67 bits at COORD_BITS = 32.
// Reset clears the stage valid bits and rsp_valid only.
// The pipeline holds only while its last stage is full and the rsp beat waits;
// otherwise req beats are taken even while an rsp beat is stalled.
module orient_incircle_predicate_unit
   import oip_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int D_W   = COORD_BITS + 1;
   localparam int SQ_W  = 2 * D_W;
   localparam int P_W   = 2 * D_W + 1;
   localparam int M2_W  = D_W + P_W;
   localparam int T1_W  = M2_W + 1;
   localparam int M3_W  = D_W + T1_W;
   localparam int S_W   = M3_W + 1;
   localparam int DET_W = S_W + 1;
   localparam int LEV1  = oip_clog2(oip_chunks(D_W) * oip_chunks(D_W));
   localparam int LEV2  = oip_clog2(oip_chunks(D_W) * oip_chunks(P_W));
   localparam int LEV3A = oip_clog2(oip_chunks(D_W) * oip_chunks(T1_W));
   localparam int LEV3B = oip_clog2(oip_chunks(P_W) * oip_chunks(P_W));
   localparam int LEV3  = (LEV3A > LEV3B) ? LEV3A : LEV3B;
   localparam int L1    = LEV1 + 1;
   localparam int L2    = LEV2 + 1;
   localparam int L3    = LEV3 + 1;
   localparam int NSTG  = L1 + L2 + L3 + 5;

   logic              stage_en;
   logic              out_free;
   logic [NSTG-1:0]   vld_in;
   logic [NSTG-1:0]   vld_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_in;
   rsp_type           rsp_data_ff;

   // translate to the query point; orientation uses a as the origin
   logic signed [D_W-1:0] qx, qy;
   logic signed [D_W-1:0] adx_in, ady_in, bdx_in, bdy_in, cdx_in, cdy_in;
   logic signed [D_W-1:0] adx_ff, ady_ff, bdx_ff, bdy_ff, cdx_ff, cdy_ff;
   logic                  act_ff;

   logic signed [SQ_W-1:0] sq_ax, sq_ay, sq_bx, sq_by, sq_cx, sq_cy, pr_bxcy, pr_bycx;
   logic [4*D_W-1:0]       bc_dly;
   logic [2*D_W-1:0]       a_dly;
   logic                   act_dly;
   logic signed [D_W-1:0]  bdx2, bdy2, cdx2, cdy2, adx3, ady3;

   logic signed [P_W-1:0]  ap_in, bp_in, cp_in, t3_in;
   logic signed [P_W-1:0]  ap_ff, bp_ff, cp_ff, t3_ff;
   logic [2*P_W-1:0]       pt_dly;
   logic signed [P_W-1:0]  ap2, t32;

   logic signed [M2_W-1:0] m_bycp, m_bpcy, m_bxcp, m_bpcx;
   logic signed [T1_W-1:0] t1_in, t2_in, t1_ff, t2_ff;
   logic signed [1:0]      orient_in;
   logic [1:0]             orient_dly;

   logic signed [M3_W-1:0]  p1, p2, p3;
   logic signed [S_W-1:0]   s_in, s_ff;
   logic signed [M3_W-1:0]  p3_ff;
   logic signed [DET_W-1:0] det_in, det_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign stage_en  = !vld_ff[NSTG-1] || out_free;
   assign req_stall = !stage_en;
   assign vld_in    = {vld_ff[NSTG-2:0], req_valid};

   always_comb begin
      if (req_data.action == ACT_INCIRCLE) begin
         qx = D_W'($signed(req_data.dx[COORD_BITS-1:0]));
         qy = D_W'($signed(req_data.dy[COORD_BITS-1:0]));
      end else begin
         qx = D_W'($signed(req_data.ax[COORD_BITS-1:0]));
         qy = D_W'($signed(req_data.ay[COORD_BITS-1:0]));
      end
      adx_in = D_W'($signed(req_data.ax[COORD_BITS-1:0])) - qx;
      ady_in = D_W'($signed(req_data.ay[COORD_BITS-1:0])) - qy;
      bdx_in = D_W'($signed(req_data.bx[COORD_BITS-1:0])) - qx;
      bdy_in = D_W'($signed(req_data.by_coord[COORD_BITS-1:0])) - qy;
      cdx_in = D_W'($signed(req_data.cx[COORD_BITS-1:0])) - qx;
      cdy_in = D_W'($signed(req_data.cy[COORD_BITS-1:0])) - qy;
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         adx_ff <= adx_in;
         ady_ff <= ady_in;
         bdx_ff <= bdx_in;
         bdy_ff <= bdy_in;
         cdx_ff <= cdx_in;
         cdy_ff <= cdy_in;
         act_ff <= req_data.action;
      end
   end

   oip_mul #(.A_W(D_W), .B_W(D_W), .LEVELS(LEV1)) u_sq_ax (
      .clock(clock), .en(stage_en), .a(adx_ff), .b(adx_ff), .p(sq_ax));
   oip_mul #(.A_W(D_W), .B_W(D_W), .LEVELS(LEV1)) u_sq_ay (
      .clock(clock), .en(stage_en), .a(ady_ff), .b(ady_ff), .p(sq_ay));
   oip_mul #(.A_W(D_W), .B_W(D_W), .LEVELS(LEV1)) u_sq_bx (
      .clock(clock), .en(stage_en), .a(bdx_ff), .b(bdx_ff), .p(sq_bx));
   oip_mul #(.A_W(D_W), .B_W(D_W), .LEVELS(LEV1)) u_sq_by (
      .clock(clock), .en(stage_en), .a(bdy_ff), .b(bdy_ff), .p(sq_by));
   oip_mul #(.A_W(D_W), .B_W(D_W), .LEVELS(LEV1)) u_sq_cx (
      .clock(clock), .en(stage_en), .a(cdx_ff), .b(cdx_ff), .p(sq_cx));
   oip_mul #(.A_W(D_W), .B_W(D_W), .LEVELS(LEV1)) u_sq_cy (
      .clock(clock), .en(stage_en), .a(cdy_ff), .b(cdy_ff), .p(sq_cy));
   oip_mul #(.A_W(D_W), .B_W(D_W), .LEVELS(LEV1)) u_pr_bxcy (
      .clock(clock), .en(stage_en), .a(bdx_ff), .b(cdy_ff), .p(pr_bxcy));
   oip_mul #(.A_W(D_W), .B_W(D_W), .LEVELS(LEV1)) u_pr_bycx (
      .clock(clock), .en(stage_en), .a(bdy_ff), .b(cdx_ff), .p(pr_bycx));

   oip_delay #(.WIDTH(4*D_W), .DEPTH(L1+1)) u_dly_bc (
      .clock(clock), .en(stage_en), .d({bdx_ff, bdy_ff, cdx_ff, cdy_ff}), .q(bc_dly));
   oip_delay #(.WIDTH(2*D_W), .DEPTH(L1+L2+2)) u_dly_a (
      .clock(clock), .en(stage_en), .d({adx_ff, ady_ff}), .q(a_dly));
   oip_delay #(.WIDTH(1), .DEPTH(L1+L2+L3+4)) u_dly_act (
      .clock(clock), .en(stage_en), .d(act_ff), .q(act_dly));

   assign bdx2 = $signed(bc_dly[4*D_W-1 -: D_W]);
   assign bdy2 = $signed(bc_dly[3*D_W-1 -: D_W]);
   assign cdx2 = $signed(bc_dly[2*D_W-1 -: D_W]);
   assign cdy2 = $signed(bc_dly[D_W-1:0]);
   assign adx3 = $signed(a_dly[2*D_W-1 -: D_W]);
   assign ady3 = $signed(a_dly[D_W-1:0]);

   // lifts and the orientation term
   assign ap_in = P_W'(sq_ax) + P_W'(sq_ay);
   assign bp_in = P_W'(sq_bx) + P_W'(sq_by);
   assign cp_in = P_W'(sq_cx) + P_W'(sq_cy);
   assign t3_in = P_W'(pr_bxcy) - P_W'(pr_bycx);

   always_ff @(posedge clock) begin
      if (stage_en) begin
         ap_ff <= ap_in;
         bp_ff <= bp_in;
         cp_ff <= cp_in;
         t3_ff <= t3_in;
      end
   end

   oip_mul #(.A_W(D_W), .B_W(P_W), .LEVELS(LEV2)) u_m_bycp (
      .clock(clock), .en(stage_en), .a(bdy2), .b(cp_ff), .p(m_bycp));
   oip_mul #(.A_W(D_W), .B_W(P_W), .LEVELS(LEV2)) u_m_bpcy (
      .clock(clock), .en(stage_en), .a(cdy2), .b(bp_ff), .p(m_bpcy));
   oip_mul #(.A_W(D_W), .B_W(P_W), .LEVELS(LEV2)) u_m_bxcp (
      .clock(clock), .en(stage_en), .a(bdx2), .b(cp_ff), .p(m_bxcp));
   oip_mul #(.A_W(D_W), .B_W(P_W), .LEVELS(LEV2)) u_m_bpcx (
      .clock(clock), .en(stage_en), .a(cdx2), .b(bp_ff), .p(m_bpcx));

   oip_delay #(.WIDTH(2*P_W), .DEPTH(L2+1)) u_dly_pt (
      .clock(clock), .en(stage_en), .d({ap_ff, t3_ff}), .q(pt_dly));

   assign ap2 = $signed(pt_dly[2*P_W-1 -: P_W]);
   assign t32 = $signed(pt_dly[P_W-1:0]);

   assign t1_in = T1_W'(m_bycp) - T1_W'(m_bpcy);
   assign t2_in = T1_W'(m_bxcp) - T1_W'(m_bpcx);

   always_comb begin
      priority if (t32 == '0) begin
         orient_in = ORIENT_COLLINEAR;
      end else if (t32[P_W-1]) begin
         orient_in = ORIENT_CW;
      end else begin
         orient_in = ORIENT_CCW;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         t1_ff <= t1_in;
         t2_ff <= t2_in;
      end
   end

   oip_delay #(.WIDTH(2), .DEPTH(L3+2)) u_dly_orient (
      .clock(clock), .en(stage_en), .d(orient_in), .q(orient_dly));

   oip_mul #(.A_W(D_W), .B_W(T1_W), .LEVELS(LEV3)) u_p1 (
      .clock(clock), .en(stage_en), .a(adx3), .b(t1_ff), .p(p1));
   oip_mul #(.A_W(D_W), .B_W(T1_W), .LEVELS(LEV3)) u_p2 (
      .clock(clock), .en(stage_en), .a(ady3), .b(t2_ff), .p(p2));
   oip_mul #(.A_W(P_W), .B_W(P_W), .LEVELS(LEV3)) u_p3 (
      .clock(clock), .en(stage_en), .a(ap2), .b(t32), .p(p3));

   assign s_in   = S_W'(p1) - S_W'(p2);
   assign det_in = DET_W'(s_ff) + DET_W'(p3_ff);

   always_ff @(posedge clock) begin
      if (stage_en) begin
         s_ff   <= s_in;
         p3_ff  <= p3;
         det_ff <= det_in;
      end
   end

   always_comb begin
      rsp_data_in = '0;
      if (act_dly == ACT_ORIENT) begin
         rsp_data_in.orient_sign = $signed(orient_dly);
      end else begin
         rsp_data_in.orient_sign = ORIENT_COLLINEAR;
      end
      rsp_data_in.inside_circle = (act_dly == ACT_INCIRCLE) && !det_ff[DET_W-1]
                                  && (det_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (stage_en) begin
            vld_ff <= vld_in;
         end
         if (out_free) begin
            rsp_valid_ff <= vld_ff[NSTG-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && vld_ff[NSTG-1]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NSTG-1] && !out_free) |=> vld_ff[NSTG-1])
      else $error("last stage beat dropped while rsp stalled");

   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !vld_ff[NSTG-1]) |=> !rsp_valid_ff)
      else $error("rsp beat repeated");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.orient_sign == ORIENT_COLLINEAR
                        || !rsp_data_ff.inside_circle))
      else $error("both predicate results set in one beat");

endmodule

FILE: test/orient_incircle_predicate_unit_test.sv
`timescale 1ns / 1ps

module orient_incircle_predicate_unit_test;
   import oip_pkg::*;

   localparam int COORD_BITS_TB = COORD_BITS_DEFAULT;
   localparam int WB            = 192;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int MIN_C         = 32'h8000_0000;
   localparam int MAX_C         = 32'h7fff_ffff;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type req_backlog[$];
   rsp_type predicted_rsp[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_ask       = 0;
   int hold_taken     = 0;
   int hold_left      = 0;
   int error_count    = 0;
   int checked_count  = 0;
   int orient_count   = 0;
   int incircle_count = 0;
   int inside_count   = 0;
   int cycle_count    = 0;

   orient_incircle_predicate_unit #(.COORD_BITS(COORD_BITS_TB)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [WB-1:0] coord_value(input logic [FIELD_BITS-1:0] raw);
      logic signed [WB-1:0] v;
      v = '0;
      v[FIELD_BITS-1:0] = raw;
      v = v <<< (WB - COORD_BITS_TB);
      return v >>> (WB - COORD_BITS_TB);
   endfunction

   function automatic rsp_type predict_predicate(input req_type r);
      logic signed [WB-1:0] pax, pay, pbx, pby, pcx, pcy, pdx, pdy, ap, bp, cp, det;
      rsp_type res;
      pax = coord_value(r.ax);
      pay = coord_value(r.ay);
      pbx = coord_value(r.bx);
      pby = coord_value(r.by_coord);
      pcx = coord_value(r.cx);
      pcy = coord_value(r.cy);
      pdx = coord_value(r.dx);
      pdy = coord_value(r.dy);
      res = '0;
      if (r.action == ACT_ORIENT) begin
         det = (pbx - pax) * (pcy - pay) - (pby - pay) * (pcx - pax);
         if (det > 0) begin
            res.orient_sign = ORIENT_CCW;
         end else if (det < 0) begin
            res.orient_sign = ORIENT_CW;
         end else begin
            res.orient_sign = ORIENT_COLLINEAR;
         end
      end else begin
         pax = pax - pdx;
         pay = pay - pdy;
         pbx = pbx - pdx;
         pby = pby - pdy;
         pcx = pcx - pdx;
         pcy = pcy - pdy;
         ap  = pax * pax + pay * pay;
         bp  = pbx * pbx + pby * pby;
         cp  = pcx * pcx + pcy * pcy;
         det = pax * (pby * cp - bp * pcy) - pay * (pbx * cp - bp * pcx)
               + ap * (pbx * pcy - pby * pcx);
         res.inside_circle = (det > 0);
      end
      return res;
   endfunction

   function automatic int circle_x(input int idx);
      case (idx)
         0:       return 5;
         1:       return 4;
         2:       return 3;
         3:       return 0;
         4:       return -3;
         5:       return -4;
         6:       return -5;
         7:       return -4;
         8:       return -3;
         9:       return 0;
         10:      return 3;
         default: return 4;
      endcase
   endfunction

   function automatic int pick_extreme();
      case ($urandom_range(5))
         0:       return MIN_C;
         1:       return MAX_C;
         2:       return 0;
         3:       return -1;
         4:       return 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_request();
      req_type r;
      int      c[8];
      int      kind, ox, oy, s, k, dxv, dyv, idx;
      r.action = 1'($urandom_range(1));
      kind = $urandom_range(99);
      ox = int'($urandom_range(1 << 30)) - (1 << 29);
      oy = int'($urandom_range(1 << 30)) - (1 << 29);
      if (kind < 20) begin
         for (int i = 0; i < 8; i++) c[i] = $urandom;
      end else if (kind < 45) begin
         for (int i = 0; i < 8; i++) c[i] = int'($urandom_range(16)) - 8;
      end else if (kind < 65) begin
         dxv = int'($urandom_range(2048)) - 1024;
         dyv = int'($urandom_range(2048)) - 1024;
         for (int j = 0; j < 3; j++) begin
            k = int'($urandom_range(1024)) - 512;
            c[2*j]   = ox + k * dxv;
            c[2*j+1] = oy + k * dyv;
         end
         if ($urandom_range(3) == 0) c[5] = c[5] + ($urandom_range(1) ? 1 : -1);
         c[6] = ox + int'($urandom_range(64)) - 32;
         c[7] = $urandom;
      end else if (kind < 90) begin
         r.action = ($urandom_range(9) != 0) ? ACT_INCIRCLE : ACT_ORIENT;
         s = $urandom_range(1 << 20, 1);
         for (int j = 0; j < 4; j++) begin
            idx = $urandom_range(11);
            c[2*j]   = ox + s * circle_x(idx);
            c[2*j+1] = oy + s * circle_x((idx + 9) % 12);
         end
         case ($urandom_range(3))
            0: ;
            1: begin
               c[6] = ox;
               c[7] = oy;
            end
            2: begin
               c[6] = c[6] + int'($urandom_range(2)) - 1;
               c[7] = c[7] + int'($urandom_range(2)) - 1;
            end
            default: begin
               c[6] = ox + ($urandom_range(1) ? 6 * s : -6 * s);
               c[7] = oy;
            end
         endcase
      end else begin
         for (int i = 0; i < 8; i++) c[i] = pick_extreme();
      end
      r.ax       = c[0];
      r.ay       = c[1];
      r.bx       = c[2];
      r.by_coord = c[3];
      r.cx       = c[4];
      r.cy       = c[5];
      r.dx       = c[6];
      r.dy       = c[7];
      return r;
   endfunction

   task automatic append_request(input req_type r);
      req_backlog = {req_backlog, r};
   endtask

   task automatic append_expected(input rsp_type e);
      predicted_rsp = {predicted_rsp, e};
   endtask

   task automatic add_request(input logic act, input int a_x, a_y, b_x, b_y,
                              input int c_x, c_y, d_x, d_y);
      req_type r;
      r.action   = act;
      r.ax       = a_x;
      r.ay       = a_y;
      r.bx       = b_x;
      r.by_coord = b_y;
      r.cx       = c_x;
      r.cy       = c_y;
      r.dx       = d_x;
      r.dy       = d_y;
      append_request(r);
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_valid || predicted_rsp.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int n,
                            input bit with_hold);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (with_hold) hold_ask++;
      for (int i = 0; i < n; i++) append_request(make_request());
      wait_drained();
   endtask

   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            append_expected(predict_predicate(req_data));
            if (req_data.action == ACT_ORIENT) orient_count++;
            else incircle_count++;
         end
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      logic    stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               $error("unexpected rsp beat: orient_sign %0d, inside_circle %0d",
                      $signed(rsp_data.orient_sign), rsp_data.inside_circle);
               error_count++;
            end else begin
               want = predicted_rsp.pop_front();
               checked_count++;
               if (want.inside_circle) inside_count++;
               if (rsp_data.orient_sign !== want.orient_sign) begin
                  $error("orient_sign: expected %0d, actual %0d",
                         $signed(want.orient_sign), $signed(rsp_data.orient_sign));
                  error_count++;
               end
               if (rsp_data.inside_circle !== want.inside_circle) begin
                  $error("inside_circle: expected %0d, actual %0d",
                         want.inside_circle, rsp_data.inside_circle);
                  error_count++;
               end
            end
         end
         if (hold_taken != hold_ask) begin
            hold_taken = hold_ask;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            stall_next = ($urandom_range(99) < recv_stall_pct);
         end
         rsp_stall <= stall_next;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("orient_incircle_predicate_unit_test: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_request(ACT_ORIENT, 0, 0, 0, 0, 0, 0, 0, 0);
      add_request(ACT_ORIENT, 0, 0, 1, 0, 0, 1, 0, 0);
      add_request(ACT_ORIENT, 0, 0, 0, 1, 1, 0, 0, 0);
      add_request(ACT_ORIENT, MIN_C, MIN_C, MAX_C, MIN_C, MIN_C, MAX_C, 0, 0);
      add_request(ACT_ORIENT, MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, 0, 0);
      add_request(ACT_ORIENT, MIN_C, MIN_C, MAX_C, MAX_C, 0, 0, MAX_C, MIN_C);
      add_request(ACT_ORIENT, 0, 0, 1, 0, 0, 1, MIN_C, MAX_C);
      add_request(ACT_ORIENT, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C);
      add_request(ACT_ORIENT, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                  -1, 1, 32'h5555_5555, 32'haaaa_aaaa);
      add_request(ACT_INCIRCLE, 0, 0, 4, 0, 0, 4, 1, 1);
      add_request(ACT_INCIRCLE, 0, 0, 4, 0, 0, 4, 5, 5);
      add_request(ACT_INCIRCLE, 0, 0, 4, 0, 0, 4, 4, 4);
      add_request(ACT_INCIRCLE, 0, 0, 0, 4, 4, 0, 1, 1);
      add_request(ACT_INCIRCLE, 0, 0, 0, 4, 4, 0, 5, 5);
      add_request(ACT_INCIRCLE, 0, 0, 1, 1, 2, 2, 7, -3);
      add_request(ACT_INCIRCLE, 0, 0, 4, 0, 0, 4, 0, 0);
      add_request(ACT_INCIRCLE, MIN_C, MIN_C, MAX_C, MIN_C, MIN_C, MAX_C, 0, 0);
      add_request(ACT_INCIRCLE, MIN_C, MIN_C, MAX_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C);
      add_request(ACT_INCIRCLE, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C);
      add_request(ACT_INCIRCLE, 0, 0, 4, 0, 0, 4, MIN_C, MIN_C);
      add_request(ACT_INCIRCLE, 32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa,
                  1, -1, MAX_C, MIN_C);
      wait_drained();

      run_phase(0, 0, 80, 1'b0);
      run_phase(54, 0, 80, 1'b0);
      run_phase(0, 54, 80, 1'b0);
      run_phase(25, 25, 80, 1'b0);
      run_phase(0, 0, 80, 1'b1);

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (predicted_rsp.size() != 0) begin
         $error("%0d predicted rsp beats never arrived", predicted_rsp.size());
         error_count++;
      end
      $display("Covered %0d orientation and %0d incircle requests (%0d inside) over five",
               orient_count, incircle_count, inside_count);
      $display("idle/stall mixes incl. a long rsp hold-off; %0d rsp beats checked",
               checked_count);
      if (error_count == 0) begin
         $display("orient_incircle_predicate_unit_test: done, clean");
      end else begin
         $display("orient_incircle_predicate_unit_test: done, errors");
      end
      $finish;
   end

endmodule

FILE: files.f
design/oip_pkg.sv
design/oip_delay.sv
design/oip_mul.sv
design/orient_incircle_predicate_unit.sv
test/orient_incircle_predicate_unit_test.sv
